### sv/pdu_pkg.sv
// Package for the partial deviance unit: shared constants, datapath commands,
// status bundle and controller state encoding.
// No dependencies.
package pdu_pkg;

  // Operand and result widths
  localparam int IN_W     = 40;
  localparam int OUT_W    = 48;
  localparam int LOG_FRAC = 56;

  // ln(2) in Q62, rounded to nearest
  localparam logic [63:0] LN2_Q62 = 64'h2C5C85FDF473DE6B;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_MUL,
    OP_DIV,
    OP_TERM_NEXT,
    OP_LOG_LOAD,
    OP_NORM,
    OP_LOG_STORE,
    OP_DM,
    OP_SER_END,
    OP_DIR_END,
    OP_FINISH
  } dp_op_t;

  // Multiplier operand pairs (each implies a result shift)
  typedef enum logic [2:0] {
    MS_UU,
    MS_PW,
    MS_DU,
    MS_AS,
    MS_MM,
    MS_DLN,
    MS_ALN
  } mul_src_t;

  // Divider jobs
  typedef enum logic {
    DS_FRAC,
    DS_TERM
  } div_src_t;

  // Item class after operand checks
  typedef enum logic [1:0] {
    CL_SPECIAL,
    CL_SERIES,
    CL_DIRECT
  } cls_t;

  typedef struct packed {
    dp_op_t   op;
    mul_src_t mul_src;
    div_src_t div_src;
    logic     log_b;
  } dp_cmd_t;

  typedef struct packed {
    cls_t cls;
    logic mul_done;
    logic div_done;
    logic m_norm;
    logic term_last;
    logic iter_last;
    logic log_b;
    logic out_free;
  } dp_status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_CLASS,
    ST_DIVU_WAIT,
    ST_MULW_GO,
    ST_MULW_WAIT,
    ST_MULP_GO,
    ST_MULP_WAIT,
    ST_DIVP_GO,
    ST_DIVP_WAIT,
    ST_MULT1_GO,
    ST_MULT1_WAIT,
    ST_MULT2_GO,
    ST_MULT2_WAIT,
    ST_SER_END,
    ST_NORM,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_LOG_STORE,
    ST_LOGB,
    ST_DM,
    ST_DLN_GO,
    ST_DLN_WAIT,
    ST_ALN_GO,
    ST_ALN_WAIT,
    ST_DIR_END,
    ST_FINISH
  } state_t;

endpackage

### sv/partial_deviance_unit.sv
// Partial deviance d0 = a*ln(a/b) + b - a on 40-bit fixed point; uses pdu_ctrl, pdu_dp.
// One item at a time. Series: a 60-step division, then per term a multiply and a
// division. Direct: ka and kb up to 39 normalize shifts, 2*56 squarings.
// Synchronous reset clears the controller, the output valid and the busy and done flags
// of the multiplier and divider; no other state.
module partial_deviance_unit
  import pdu_pkg::*;
#(
  parameter int SERIES_TERMS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [IN_W-1:0]   a_value,
  input  logic [IN_W-1:0]   b_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  deviance,
  output logic              saturated,
  output logic              invalid_input
);

  dp_cmd_t    cmd;
  dp_status_t status;

  pdu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pdu_dp #(
    .SERIES_TERMS (SERIES_TERMS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .a_in          (a_value),
    .b_in          (b_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .deviance      (deviance),
    .saturated     (saturated),
    .invalid_input (invalid_input)
  );

endmodule

### sv/pdu_mul.sv
// Multi-cycle 64x64 -> 128 unsigned multiplier built from one 32x32 multiplier.
// Four partial products, each registered before it is accumulated.
// Depends on nothing.
module pdu_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  x,
  input  logic [63:0]  y,
  output logic         busy,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0]  xr, yr;
  logic [63:0]  pp;
  logic [1:0]   pp_tag;
  logic [2:0]   ph;
  logic [31:0]  xs, ys;
  logic [63:0]  pp_next;
  logic [127:0] pp_sh;
  logic [127:0] acc;

  // Partial product select: lo*lo, lo*hi, hi*lo, hi*hi
  assign xs      = ph[1] ? xr[63:32] : xr[31:0];
  assign ys      = ph[0] ? yr[63:32] : yr[31:0];
  assign pp_next = xs * ys;

  // Align the registered partial product
  always_comb begin
    case (pp_tag)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xr   <= x;
        yr   <= y;
        acc  <= '0;
        ph   <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (ph != 3'd4) begin
          pp     <= pp_next;
          pp_tag <= ph[1:0];
        end
        if (ph != 3'd0) begin
          acc <= acc + pp_sh;
        end
        if (ph == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        ph <= ph + 3'd1;
      end
    end
  end

  assign prod = acc;

endmodule

### sv/pdu_div.sv
// Restoring divider, one quotient bit per cycle.
// Fraction job: remainder starts at num (num < den), 60 steps. Integer job: 64 steps.
// Depends on nothing.
module pdu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        frac,
  input  logic [63:0] num,
  input  logic [40:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [40:0] rem;
  logic [63:0] dvd;
  logic [40:0] den_r;
  logic [6:0]  cnt;
  logic        busy;
  logic [41:0] rs, rs_sub;
  logic        ge;

  // One restoring step
  assign rs     = {rem, dvd[63]};
  assign ge     = rs >= {1'b0, den_r};
  assign rs_sub = rs - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= frac ? num[40:0] : '0;
        dvd   <= frac ? '0 : num;
        den_r <= den;
        quo   <= '0;
        cnt   <= frac ? 7'd60 : 7'd64;
        busy  <= 1'b1;
      end else if (busy) begin
        rem <= ge ? rs_sub[40:0] : rs[40:0];
        dvd <= {dvd[62:0], 1'b0};
        quo <= {quo[62:0], ge};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/pdu_dp.sv
// Datapath of the partial deviance unit: operand registers, series and log
// registers, shared multiplier and divider, output register.
// Depends on pdu_pkg, pdu_mul, pdu_div.
module pdu_dp
  import pdu_pkg::*;
#(
  parameter int SERIES_TERMS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic [IN_W-1:0]   a_in,
  input  logic [IN_W-1:0]   b_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  deviance,
  output logic              saturated,
  output logic              invalid_input
);

  localparam int JW = $clog2(SERIES_TERMS + 1);

  logic [IN_W-1:0] a_r, b_r, diff;
  logic [IN_W:0]   sum;
  logic            a_big;
  cls_t            cls_r;
  logic signed [65:0] d_r;
  logic            inv_r;
  logic [63:0]     u, w, p, s, t1, t2, ln, t;
  logic [JW-1:0]   j;
  logic [63:0]     m;
  logic [5:0]      n;
  logic [55:0]     r;
  logic [5:0]      it;
  logic            log_b;
  logic [61:0]     la, lb, dm;
  logic            d_pos;
  mul_src_t        mul_src_r;
  div_src_t        div_src_r;

  // Operand checks on the captured item
  logic            a_gt, a_zero, b_zero, ab_eq;
  logic [IN_W-1:0] diff_c;
  logic [IN_W:0]   sum_c;
  cls_t            cls_c;

  assign a_gt   = a_r > b_r;
  assign a_zero = a_r == '0;
  assign b_zero = b_r == '0;
  assign ab_eq  = a_r == b_r;
  assign diff_c = a_gt ? a_r - b_r : b_r - a_r;
  assign sum_c  = {1'b0, a_r} + {1'b0, b_r};

  always_comb begin
    if (a_zero || ab_eq || b_zero) begin
      cls_c = CL_SPECIAL;
    end else if ({diff_c, 3'b000} < {2'b00, sum_c}) begin
      cls_c = CL_SERIES;
    end else begin
      cls_c = CL_DIRECT;
    end
  end

  // Shared multiplier
  logic         mul_start, mul_busy, mul_done;
  logic [63:0]  mul_x, mul_y, mul_res;
  logic [127:0] mul_prod;

  assign mul_start = cmd.op == OP_MUL;

  always_comb begin
    case (cmd.mul_src)
      MS_UU:   begin mul_x = u;              mul_y = u;       end
      MS_PW:   begin mul_x = p;              mul_y = w;       end
      MS_DU:   begin mul_x = {24'd0, diff};  mul_y = u;       end
      MS_AS:   begin mul_x = {24'd0, a_r};   mul_y = s;       end
      MS_MM:   begin mul_x = m;              mul_y = m;       end
      MS_DLN:  begin mul_x = {2'b00, dm};    mul_y = LN2_Q62; end
      default: begin mul_x = {24'd0, a_r};   mul_y = ln;      end
    endcase
  end

  pdu_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Product scaling per operand pair
  always_comb begin
    case (mul_src_r) inside
      MS_MM, MS_DLN: mul_res = mul_prod[125:62];
      MS_AS:         mul_res = mul_prod[122:59];
      MS_ALN:        mul_res = mul_prod[119:56];
      default:       mul_res = mul_prod[123:60];
    endcase
  end

  // Shared divider
  logic        div_start, div_done, div_frac;
  logic [63:0] div_num, div_quo;
  logic [40:0] div_den;

  assign div_start = cmd.op == OP_DIV;
  assign div_frac  = cmd.div_src == DS_FRAC;
  assign div_num   = div_frac ? {24'd0, diff} : p;
  assign div_den   = div_frac ? sum : {{(41 - JW - 1){1'b0}}, j, 1'b1};

  pdu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .frac  (div_frac),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Result clamp
  logic             d_neg, d_over;
  logic [OUT_W-1:0] dev_c;

  assign d_neg  = d_r[65];
  assign d_over = !d_neg && (d_r[64:OUT_W] != '0);
  assign dev_c  = d_neg ? '0 : (d_over ? '1 : d_r[OUT_W-1:0]);

  // Working registers
  always_ff @(posedge clk) begin
    if (mul_start) mul_src_r <= cmd.mul_src;
    if (div_start) div_src_r <= cmd.div_src;

    // Unit write-back
    if (mul_done) begin
      case (mul_src_r)
        MS_UU:  w  <= mul_res;
        MS_PW:  p  <= mul_res;
        MS_DU:  t1 <= mul_res;
        MS_AS:  t2 <= mul_res;
        MS_MM: begin
          r  <= {r[54:0], mul_res[63]};
          m  <= mul_res[63] ? {1'b0, mul_res[63:1]} : mul_res;
          it <= it + 6'd1;
        end
        MS_DLN: ln <= mul_res;
        default: t <= mul_res;
      endcase
    end
    if (div_done) begin
      if (div_src_r == DS_FRAC) begin
        u <= div_quo;
        p <= div_quo;
        s <= '0;
        j <= JW'(1);
      end else begin
        s <= s + div_quo;
      end
    end

    // Sequencer operations
    unique case (cmd.op)
      OP_LOAD: begin
        a_r <= a_in;
        b_r <= b_in;
      end
      OP_PREP: begin
        a_big <= a_gt;
        diff  <= diff_c;
        sum   <= sum_c;
        cls_r <= cls_c;
        d_r   <= a_zero ? {26'd0, b_r} : '0;
        inv_r <= !a_zero && !ab_eq && b_zero;
      end
      OP_TERM_NEXT: j <= j + JW'(1);
      OP_LOG_LOAD: begin
        log_b <= cmd.log_b;
        m     <= {1'b0, (cmd.log_b ? b_r : a_r), 23'd0};
        n     <= 6'd39;
        r     <= '0;
        it    <= '0;
      end
      OP_NORM: begin
        m <= {m[62:0], 1'b0};
        n <= n - 6'd1;
      end
      OP_LOG_STORE: begin
        if (log_b) lb <= {n, r};
        else       la <= {n, r};
      end
      OP_DM: begin
        d_pos <= la >= lb;
        dm    <= (la >= lb) ? la - lb : lb - la;
      end
      OP_SER_END: begin
        if (a_big)           d_r <= {2'b00, t1} + {2'b00, t2};
        else if (t1 >= t2)   d_r <= {2'b00, t1 - t2};
        else                 d_r <= '0;
      end
      OP_DIR_END: begin
        d_r <= {26'd0, b_r} - {26'd0, a_r} + (d_pos ? {2'b00, t} : -{2'b00, t});
      end
      OP_FINISH: begin
        deviance      <= dev_c;
        saturated     <= d_over;
        invalid_input <= inv_r;
      end
      default: ;
    endcase
  end

  // Output register handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Status to the controller
  assign status.cls       = cls_r;
  assign status.mul_done  = mul_done;
  assign status.div_done  = div_done;
  assign status.m_norm    = m[62];
  assign status.term_last = j == JW'(SERIES_TERMS);
  assign status.iter_last = it == 6'(LOG_FRAC - 1);
  assign status.log_b     = log_b;
  assign status.out_free  = !out_valid || !out_stall;

`ifndef SYNTHESIS
  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_FINISH |-> (!out_valid || !out_stall))
    else $error("result written over a pending item");

  a_sq_norm: assert property (@(posedge clk) disable iff (rst)
    (mul_start && cmd.mul_src == MS_MM) |-> m[62])
    else $error("log mantissa not normalized at squaring");

  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && invalid_input) |-> (deviance == '0 && !saturated))
    else $error("invalid item with nonzero deviance");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (deviance == '1))
    else $error("saturated item below maximum");
`endif

endmodule

### sv/pdu_ctrl.sv
// Controller of the partial deviance unit: sequences the series or the direct
// evaluation through datapath commands, or finishes a special item directly.
// Depends on pdu_pkg.
module pdu_ctrl
  import pdu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = state != ST_IDLE;

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd.op      = OP_NONE;
    cmd.mul_src = MS_UU;
    cmd.div_src = DS_FRAC;
    cmd.log_b   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.op     = OP_PREP;
        state_next = ST_CLASS;
      end
      ST_CLASS: begin
        unique case (status.cls)
          CL_SERIES: begin
            cmd.op      = OP_DIV;
            cmd.div_src = DS_FRAC;
            state_next  = ST_DIVU_WAIT;
          end
          CL_DIRECT: begin
            cmd.op     = OP_LOG_LOAD;
            cmd.log_b  = 1'b0;
            state_next = ST_NORM;
          end
          default: state_next = ST_FINISH;
        endcase
      end
      // Series branch
      ST_DIVU_WAIT: if (status.div_done) state_next = ST_MULW_GO;
      ST_MULW_GO: begin
        cmd.op      = OP_MUL;
        cmd.mul_src = MS_UU;
        state_next  = ST_MULW_WAIT;
      end
      ST_MULW_WAIT: if (status.mul_done) state_next = ST_MULP_GO;
      ST_MULP_GO: begin
        cmd.op      = OP_MUL;
        cmd.mul_src = MS_PW;
        state_next  = ST_MULP_WAIT;
      end
      ST_MULP_WAIT: if (status.mul_done) state_next = ST_DIVP_GO;
      ST_DIVP_GO: begin
        cmd.op      = OP_DIV;
        cmd.div_src = DS_TERM;
        state_next  = ST_DIVP_WAIT;
      end
      ST_DIVP_WAIT: begin
        if (status.div_done) begin
          if (status.term_last) begin
            state_next = ST_MULT1_GO;
          end else begin
            cmd.op     = OP_TERM_NEXT;
            state_next = ST_MULP_GO;
          end
        end
      end
      ST_MULT1_GO: begin
        cmd.op      = OP_MUL;
        cmd.mul_src = MS_DU;
        state_next  = ST_MULT1_WAIT;
      end
      ST_MULT1_WAIT: if (status.mul_done) state_next = ST_MULT2_GO;
      ST_MULT2_GO: begin
        cmd.op      = OP_MUL;
        cmd.mul_src = MS_AS;
        state_next  = ST_MULT2_WAIT;
      end
      ST_MULT2_WAIT: if (status.mul_done) state_next = ST_SER_END;
      ST_SER_END: begin
        cmd.op     = OP_SER_END;
        state_next = ST_FINISH;
      end
      // Direct branch: log2 of a, then of b
      ST_NORM: begin
        if (status.m_norm) begin
          state_next = ST_SQ_GO;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      ST_SQ_GO: begin
        cmd.op      = OP_MUL;
        cmd.mul_src = MS_MM;
        state_next  = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (status.mul_done) begin
          state_next = status.iter_last ? ST_LOG_STORE : ST_SQ_GO;
        end
      end
      ST_LOG_STORE: begin
        cmd.op     = OP_LOG_STORE;
        state_next = status.log_b ? ST_DM : ST_LOGB;
      end
      ST_LOGB: begin
        cmd.op     = OP_LOG_LOAD;
        cmd.log_b  = 1'b1;
        state_next = ST_NORM;
      end
      ST_DM: begin
        cmd.op     = OP_DM;
        state_next = ST_DLN_GO;
      end
      ST_DLN_GO: begin
        cmd.op      = OP_MUL;
        cmd.mul_src = MS_DLN;
        state_next  = ST_DLN_WAIT;
      end
      ST_DLN_WAIT: if (status.mul_done) state_next = ST_ALN_GO;
      ST_ALN_GO: begin
        cmd.op      = OP_MUL;
        cmd.mul_src = MS_ALN;
        state_next  = ST_ALN_WAIT;
      end
      ST_ALN_WAIT: if (status.mul_done) state_next = ST_DIR_END;
      ST_DIR_END: begin
        cmd.op     = OP_DIR_END;
        state_next = ST_FINISH;
      end
      // Hand the item to the output register
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.op     = OP_FINISH;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
